/* hw/rtl/aals_pkg.sv */
// ----------------------------------------------------------------------------
// aals_pkg
// Shared types and constants of the anti-aliased line stepper.
// ----------------------------------------------------------------------------
package aals_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int CMD_DEPTH_DEF  = 2;
    localparam int RES_DEPTH_DEF  = 2;

    // Operation codes of an input transaction.
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Coverage values.
    localparam logic [7:0] ALPHA_MAX  = 8'd255;
    localparam logic [7:0] HALF_ALPHA = 8'd127;
    localparam logic [7:0] NO_ALPHA   = 8'd0;

    typedef enum logic [1:0] {
        FE_IDLE,
        FE_DIVIDE,
        FE_ISSUE
    } fe_state_t;

endpackage

/* hw/rtl/aals_fifo.sv */
// ----------------------------------------------------------------------------
// aals_fifo
// Small register queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module aals_fifo
    import aals_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = CMD_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* hw/rtl/aals_front.sv */
// ----------------------------------------------------------------------------
// aals_front
// Accepts transactions, sets up start items (axis swap, endpoint order and
// an iterative gradient divider) and issues commands to the back end.
// ----------------------------------------------------------------------------
module aals_front
    import aals_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic                  operation,
    input  logic [COORD_BITS-1:0] x_start,
    input  logic [COORD_BITS-1:0] y_start,
    input  logic [COORD_BITS-1:0] x_end,
    input  logic [COORD_BITS-1:0] y_end,
    input  logic                  cmd_full,
    output logic                  cmd_push,
    output logic                  cmd_start,
    output logic                  cmd_steep,
    output logic [COORD_BITS-1:0] cmd_x1,
    output logic [COORD_BITS-1:0] cmd_y1,
    output logic [COORD_BITS-1:0] cmd_x2,
    output logic [FRAC_BITS+1:0]  cmd_slope
);

    localparam int CW = $clog2(FRAC_BITS + 2);
    localparam logic [CW-1:0]      DIV_STEPS = CW'(FRAC_BITS + 1);
    localparam logic [CW-1:0]      CNT_LAST  = CW'(1);
    localparam logic [FRAC_BITS:0] QUO_ONE   = {1'b1, {FRAC_BITS{1'b0}}};

    fe_state_t state_reg, state_next;

    logic                  steep_reg, steep_next;
    logic                  neg_reg, neg_next;
    logic                  first_reg, first_next;
    logic [COORD_BITS-1:0] x1_reg, x1_next;
    logic [COORD_BITS-1:0] y1_reg, y1_next;
    logic [COORD_BITS-1:0] x2_reg, x2_next;
    logic [COORD_BITS-1:0] dx_reg, dx_next;
    logic [COORD_BITS:0]   rem_reg, rem_next;
    logic [FRAC_BITS:0]    quo_reg, quo_next;
    logic [CW-1:0]         cnt_reg, cnt_next;

    logic [COORD_BITS-1:0] adx, ady, sx1, sy1, sx2, sy2;
    logic [COORD_BITS-1:0] ox1, oy1, ox2, oy2, dx, mag;
    logic                  steep, swap, neg;
    logic [COORD_BITS:0]   shifted;
    logic                  ge;
    logic                  start_accept;

    // Classification of a start transaction.
    always_comb
    begin
        adx   = (x_end >= x_start) ? x_end - x_start : x_start - x_end;
        ady   = (y_end >= y_start) ? y_end - y_start : y_start - y_end;
        steep = ady > adx;
        sx1   = steep ? y_start : x_start;
        sy1   = steep ? x_start : y_start;
        sx2   = steep ? y_end : x_end;
        sy2   = steep ? x_end : y_end;
        swap  = sx1 > sx2;
        ox1   = swap ? sx2 : sx1;
        oy1   = swap ? sy2 : sy1;
        ox2   = swap ? sx1 : sx2;
        oy2   = swap ? sy1 : sy2;
        dx    = ox2 - ox1;
        neg   = oy2 < oy1;
        mag   = neg ? oy1 - oy2 : oy2 - oy1;
    end

    assign start_accept = (state_reg == FE_IDLE) && push && !cmd_full
                          && (operation == OP_START);

    // Restoring divider: the first pass compares without a shift, since the
    // minor delta never exceeds the major delta and the quotient is at most 1.0.
    assign shifted = first_reg ? rem_reg : {rem_reg[COORD_BITS-1:0], 1'b0};
    assign ge      = shifted >= {1'b0, dx_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FE_IDLE:
            begin
                if (start_accept)
                begin
                    state_next = (dx == '0) ? FE_ISSUE : FE_DIVIDE;
                end
            end
            FE_DIVIDE:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = FE_ISSUE;
                end
            end
            FE_ISSUE:
            begin
                if (!cmd_full)
                begin
                    state_next = FE_IDLE;
                end
            end
            default:
            begin
                state_next = FE_IDLE;
            end
        endcase
    end

    always_comb
    begin
        full      = (state_reg != FE_IDLE) || cmd_full;
        cmd_push  = 1'b0;
        cmd_start = 1'b0;
        case (state_reg)
            FE_IDLE:
            begin
                cmd_push = push && !cmd_full && (operation == OP_STEP);
            end
            FE_ISSUE:
            begin
                cmd_push  = !cmd_full;
                cmd_start = 1'b1;
            end
            default:
            begin
                cmd_push  = 1'b0;
                cmd_start = 1'b0;
            end
        endcase
        cmd_steep = steep_reg;
        cmd_x1    = x1_reg;
        cmd_y1    = y1_reg;
        cmd_x2    = x2_reg;
        cmd_slope = neg_reg ? -{1'b0, quo_reg} : {1'b0, quo_reg};
    end

    always_comb
    begin
        steep_next = steep_reg;
        neg_next   = neg_reg;
        first_next = first_reg;
        x1_next    = x1_reg;
        y1_next    = y1_reg;
        x2_next    = x2_reg;
        dx_next    = dx_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        if (start_accept)
        begin
            steep_next = steep;
            neg_next   = neg;
            first_next = 1'b1;
            x1_next    = ox1;
            y1_next    = oy1;
            x2_next    = ox2;
            dx_next    = dx;
            rem_next   = {1'b0, mag};
            quo_next   = (dx == '0) ? QUO_ONE : '0;
            cnt_next   = DIV_STEPS;
        end
        else if (state_reg == FE_DIVIDE)
        begin
            first_next = 1'b0;
            rem_next   = ge ? shifted - {1'b0, dx_reg} : shifted;
            quo_next   = {quo_reg[FRAC_BITS-1:0], ge};
            cnt_next   = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FE_IDLE;
            cnt_reg   <= '0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            first_reg <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        steep_reg <= steep_next;
        neg_reg   <= neg_next;
        x1_reg    <= x1_next;
        y1_reg    <= y1_next;
        x2_reg    <= x2_next;
        dx_reg    <= dx_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
    end

endmodule

/* hw/rtl/aals_back.sv */
// ----------------------------------------------------------------------------
// aals_back
// Executes start and step commands: holds the line state, runs the minor-axis
// accumulator and forms one column pair per command.
// ----------------------------------------------------------------------------
module aals_back
    import aals_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_empty,
    output logic                  cmd_pop,
    input  logic                  cmd_start,
    input  logic                  cmd_steep,
    input  logic [COORD_BITS-1:0] cmd_x1,
    input  logic [COORD_BITS-1:0] cmd_y1,
    input  logic [COORD_BITS-1:0] cmd_x2,
    input  logic [FRAC_BITS+1:0]  cmd_slope,
    input  logic                  res_full,
    output logic                  res_push,
    output logic [COORD_BITS:0]   first_x,
    output logic [COORD_BITS:0]   first_y,
    output logic [7:0]            first_alpha,
    output logic [COORD_BITS:0]   second_x,
    output logic [COORD_BITS:0]   second_y,
    output logic [7:0]            second_alpha,
    output logic                  last
);

    localparam int AW = COORD_BITS + FRAC_BITS;
    localparam int SW = FRAC_BITS + 2;
    localparam int PW = FRAC_BITS + 9;
    localparam logic [FRAC_BITS:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [PW-1:0]      ALPHA_MUL = PW'(ALPHA_MAX);

    logic                  active_reg, active_next;
    logic                  steep_reg, steep_next;
    logic [COORD_BITS-1:0] col_reg, col_next;
    logic [COORD_BITS-1:0] stop_reg, stop_next;
    logic [AW-1:0]         acc_reg, acc_next;
    logic [SW-1:0]         slope_reg, slope_next;

    logic                  go;
    logic [AW-1:0]         acc_start;
    logic                  act_start;
    logic [COORD_BITS-1:0] col_step;
    logic                  fin;
    logic [FRAC_BITS-1:0]  frac;
    logic [FRAC_BITS:0]    inv;
    logic [PW-1:0]         a1_prod, a2_prod;
    logic [COORD_BITS-1:0] col_sel, minor_sel;
    logic [COORD_BITS:0]   m1, m2, c;
    logic                  steep_sel;

    assign go       = !cmd_empty && !res_full;
    assign cmd_pop  = go;
    assign res_push = go && (cmd_start || active_reg);

    always_comb
    begin
        acc_start = {cmd_y1, {FRAC_BITS{1'b0}}}
                    + {{(AW - SW){cmd_slope[SW-1]}}, cmd_slope};
        act_start = ({1'b0, cmd_x1} + 1'b1) < {1'b0, cmd_x2};

        col_step = col_reg + 1'b1;
        fin      = ({1'b0, col_step} + 1'b1) >= {1'b0, stop_reg};
        frac     = acc_reg[FRAC_BITS-1:0];
        inv      = FRAC_ONE - {1'b0, frac};
        a1_prod  = PW'(inv) * ALPHA_MUL;
        a2_prod  = PW'(frac) * ALPHA_MUL;

        if (cmd_start)
        begin
            steep_sel    = cmd_steep;
            col_sel      = cmd_x1;
            minor_sel    = cmd_y1;
            first_alpha  = HALF_ALPHA;
            second_alpha = NO_ALPHA;
            last         = !act_start;
        end
        else
        begin
            steep_sel    = steep_reg;
            col_sel      = col_step;
            minor_sel    = acc_reg[AW-1:FRAC_BITS];
            first_alpha  = a1_prod[FRAC_BITS+7:FRAC_BITS];
            second_alpha = a2_prod[FRAC_BITS+7:FRAC_BITS];
            last         = fin;
        end

        m1 = {1'b0, minor_sel};
        m2 = {1'b0, minor_sel} + 1'b1;
        c  = {1'b0, col_sel};
        // Steep lines were traced with the axes swapped; swap them back.
        first_x  = steep_sel ? m1 : c;
        first_y  = steep_sel ? c : m1;
        second_x = steep_sel ? m2 : c;
        second_y = steep_sel ? c : m2;
    end

    always_comb
    begin
        active_next = active_reg;
        steep_next  = steep_reg;
        col_next    = col_reg;
        stop_next   = stop_reg;
        acc_next    = acc_reg;
        slope_next  = slope_reg;
        if (go && cmd_start)
        begin
            active_next = act_start;
            steep_next  = cmd_steep;
            col_next    = cmd_x1;
            stop_next   = cmd_x2;
            acc_next    = acc_start;
            slope_next  = cmd_slope;
        end
        else if (go && active_reg)
        begin
            active_next = !fin;
            col_next    = col_step;
            acc_next    = acc_reg + {{(AW - SW){slope_reg[SW-1]}}, slope_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            steep_reg  <= 1'b0;
            col_reg    <= '0;
            stop_reg   <= '0;
            acc_reg    <= '0;
            slope_reg  <= '0;
        end
        else
        begin
            active_reg <= active_next;
            steep_reg  <= steep_next;
            col_reg    <= col_next;
            stop_reg   <= stop_next;
            acc_reg    <= acc_next;
            slope_reg  <= slope_next;
        end
    end

endmodule

/* hw/rtl/antialiased_line_stepper.sv */
// ----------------------------------------------------------------------------
// antialiased_line_stepper
// Wu anti-aliased line rasterizer that emits at most one column pair per transaction.
// ----------------------------------------------------------------------------
// A start transaction (operation 0) takes two endpoints and returns the first
// endpoint column at half coverage; each step transaction (operation 1) returns
// the next column as two pixels adjacent across the minor axis, with coverage
// floor(255*(1-f)) and floor(255*f). The far endpoint column is not drawn, and
// a step with no active line returns nothing. The back end turns out one column
// per cycle while it has a command and the result queue has room. A start
// transaction holds the input through setup, FRAC_BITS+1 iterations of the
// one-bit-per-cycle gradient divider, and the issue into the command queue; the
// divider is skipped when both endpoints coincide. A result enters the output
// queue in the cycle that the back end pops its command.
// ----------------------------------------------------------------------------
module antialiased_line_stepper
    import aals_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int CMD_DEPTH  = CMD_DEPTH_DEF,
    parameter int RES_DEPTH  = RES_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic                  operation,
    input  logic [COORD_BITS-1:0] x_start,
    input  logic [COORD_BITS-1:0] y_start,
    input  logic [COORD_BITS-1:0] x_end,
    input  logic [COORD_BITS-1:0] y_end,
    output logic                  empty,
    input  logic                  pop,
    output logic [COORD_BITS:0]   first_x,
    output logic [COORD_BITS:0]   first_y,
    output logic [7:0]            first_alpha,
    output logic [COORD_BITS:0]   second_x,
    output logic [COORD_BITS:0]   second_y,
    output logic [7:0]            second_alpha,
    output logic                  last
);

    localparam int CMDW = 2 + 3 * COORD_BITS + FRAC_BITS + 2;
    localparam int RESW = 4 * (COORD_BITS + 1) + 17;

    logic                  fq_push, fq_full, fq_pop, fq_empty;
    logic                  f_start, f_steep;
    logic [COORD_BITS-1:0] f_x1, f_y1, f_x2;
    logic [FRAC_BITS+1:0]  f_slope;
    logic                  b_start, b_steep;
    logic [COORD_BITS-1:0] b_x1, b_y1, b_x2;
    logic [FRAC_BITS+1:0]  b_slope;
    logic [CMDW-1:0]       cmd_wdata, cmd_rdata;

    logic                  rq_push, rq_full;
    logic [COORD_BITS:0]   r_first_x, r_first_y, r_second_x, r_second_y;
    logic [7:0]            r_first_alpha, r_second_alpha;
    logic                  r_last;
    logic [RESW-1:0]       res_wdata, res_rdata;

    aals_front #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .operation (operation),
        .x_start   (x_start),
        .y_start   (y_start),
        .x_end     (x_end),
        .y_end     (y_end),
        .cmd_full  (fq_full),
        .cmd_push  (fq_push),
        .cmd_start (f_start),
        .cmd_steep (f_steep),
        .cmd_x1    (f_x1),
        .cmd_y1    (f_y1),
        .cmd_x2    (f_x2),
        .cmd_slope (f_slope)
    );

    assign cmd_wdata = {f_start, f_steep, f_x1, f_y1, f_x2, f_slope};

    aals_fifo #(
        .WIDTH (CMDW),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fq_push),
        .wdata (cmd_wdata),
        .full  (fq_full),
        .pop   (fq_pop),
        .rdata (cmd_rdata),
        .empty (fq_empty)
    );

    assign {b_start, b_steep, b_x1, b_y1, b_x2, b_slope} = cmd_rdata;

    aals_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_empty    (fq_empty),
        .cmd_pop      (fq_pop),
        .cmd_start    (b_start),
        .cmd_steep    (b_steep),
        .cmd_x1       (b_x1),
        .cmd_y1       (b_y1),
        .cmd_x2       (b_x2),
        .cmd_slope    (b_slope),
        .res_full     (rq_full),
        .res_push     (rq_push),
        .first_x      (r_first_x),
        .first_y      (r_first_y),
        .first_alpha  (r_first_alpha),
        .second_x     (r_second_x),
        .second_y     (r_second_y),
        .second_alpha (r_second_alpha),
        .last         (r_last)
    );

    assign res_wdata = {r_first_x, r_first_y, r_first_alpha,
                        r_second_x, r_second_y, r_second_alpha, r_last};

    aals_fifo #(
        .WIDTH (RESW),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rq_push),
        .wdata (res_wdata),
        .full  (rq_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign {first_x, first_y, first_alpha,
            second_x, second_y, second_alpha, last} = res_rdata;

endmodule

/* hw/rtl/aals_checker.sv */
// ----------------------------------------------------------------------------
// aals_checker
// Port-level checks of the line stepper, bound to the top level.
// ----------------------------------------------------------------------------
module aals_checker
    import aals_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  push,
    input logic                  full,
    input logic                  operation,
    input logic [COORD_BITS-1:0] x_start,
    input logic [COORD_BITS-1:0] y_start,
    input logic [COORD_BITS-1:0] x_end,
    input logic [COORD_BITS-1:0] y_end,
    input logic                  empty,
    input logic                  pop,
    input logic [COORD_BITS:0]   first_x,
    input logic [COORD_BITS:0]   first_y,
    input logic [7:0]            first_alpha,
    input logic [COORD_BITS:0]   second_x,
    input logic [COORD_BITS:0]   second_y,
    input logic [7:0]            second_alpha,
    input logic                  last
);

    logic [8:0] alpha_sum;

    assign alpha_sum = {1'b0, first_alpha} + {1'b0, second_alpha};

    // The result queue is cleared by reset.
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result queue not empty in reset");

    // A start transaction occupies the front end for the gradient setup.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        push && !full && (operation == OP_START) |=> full)
        else $error("front end took a transaction during start setup");

    // Coverage of a column pair sums to 127 (endpoint) or to 254 or 255 (step).
    a_alpha_sum: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (alpha_sum == 9'd127 || alpha_sum == 9'd254 || alpha_sum == 9'd255))
        else $error("column coverage does not add up");

    // The second pixel sits one further along the minor axis.
    a_pair_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((first_x == second_x && second_y == first_y + 1'b1)
                 || (first_y == second_y && second_x == first_x + 1'b1)))
        else $error("column pixels are not adjacent");

    // A waiting result holds until it is taken.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(first_x) && $stable(first_y)
            && $stable(first_alpha) && $stable(second_alpha) && $stable(last))
        else $error("waiting result changed");

endmodule

bind antialiased_line_stepper aals_checker #(.COORD_BITS(COORD_BITS)) u_aals_checker (.*);
